[sv/mrtb_pkg.sv]
package mrtb_pkg;

	localparam int unsigned TARGET_W  = 4;
	localparam int unsigned VALUE_W   = 8;
	localparam int unsigned EVENTS_W  = 7;
	localparam int unsigned MINUTE_W  = 6;
	localparam int unsigned HOUR_W    = 5;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned SLEEP_W   = 10;
	localparam int unsigned LV_W      = 3;
	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned PDATA_W   = 32;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [TARGET_W-1:0] TGT_CHARGER    = 4'd0;
	localparam logic [TARGET_W-1:0] TGT_ALARM      = 4'd1;
	localparam logic [TARGET_W-1:0] TGT_OVERLAY    = 4'd2;
	localparam logic [TARGET_W-1:0] TGT_MINUTE     = 4'd3;
	localparam logic [TARGET_W-1:0] TGT_HOUR       = 4'd4;
	localparam logic [TARGET_W-1:0] TGT_SLEEP_MODE = 4'd5;
	localparam logic [TARGET_W-1:0] TGT_CLEAR      = 4'd6;
	localparam logic [TARGET_W-1:0] TGT_FAST_DELAY = 4'd7;
	localparam logic [TARGET_W-1:0] TGT_SLOW_DELAY = 4'd8;

	localparam logic [2:0] REG_SLEEP_ONE   = 3'd0;
	localparam logic [2:0] REG_SLEEP_TWO   = 3'd1;
	localparam logic [2:0] REG_SLEEP_THREE = 3'd2;
	localparam logic [2:0] REG_SLEEP_FOUR  = 3'd3;
	localparam logic [2:0] REG_LOW_VOLT    = 3'd4;
	localparam logic [2:0] REG_WATCHDOG    = 3'd5;

	localparam logic [2:0] SLEEP_OFF   = 3'd0;
	localparam logic [2:0] SLEEP_ONE   = 3'd1;
	localparam logic [2:0] SLEEP_TWO   = 3'd2;
	localparam logic [2:0] SLEEP_THREE = 3'd3;
	localparam logic [2:0] SLEEP_FOUR  = 3'd4;

	localparam logic [SLEEP_W-1:0] SLEEP_ONE_RST   = 10'd15;
	localparam logic [SLEEP_W-1:0] SLEEP_TWO_RST   = 10'd30;
	localparam logic [SLEEP_W-1:0] SLEEP_THREE_RST = 10'd60;
	localparam logic [SLEEP_W-1:0] SLEEP_FOUR_RST  = 10'd420;
	localparam logic [LV_W-1:0]    LOW_VOLT_RST    = 3'd4;
	localparam logic [COUNT_W-1:0] WATCHDOG_RST    = 8'd150;

	localparam logic [MINUTE_W-1:0] MINUTE_MAX   = 6'd59;
	localparam logic [HOUR_W-1:0]   HOUR_MAX     = 5'd23;
	localparam logic [MINUTE_W-1:0] SEC_PER_MIN  = 6'd60;
	localparam logic [COUNT_W-1:0]  SLOTS_HALF   = 8'd100;
	localparam logic [COUNT_W-1:0]  SLOTS_SECOND = 8'd200;
	localparam logic [COUNT_W-1:0]  COUNT_HOLD   = 8'hFF;

	function automatic logic is_mult3(input logic [3:0] v);
		return (v == 4'd0) || (v == 4'd3) || (v == 4'd6) || (v == 4'd9) ||
			(v == 4'd12) || (v == 4'd15);
	endfunction

	function automatic logic is_mult5(input logic [3:0] v);
		return (v == 4'd0) || (v == 4'd5) || (v == 4'd10) || (v == 4'd15);
	endfunction

	function automatic logic [COUNT_W-1:0] hold_dec(input logic [COUNT_W-1:0] v);
		return ((v != '0) && (v != COUNT_HOLD)) ? v - 1'b1 : v;
	endfunction

endpackage

[sv/multi_rate_time_base_with_sleep_timer_core.sv]
// Millisecond time base with hour:minute clock, blink flags, watchdog kick, low-voltage
// shutdown, per-second countdowns, fast/slow delays and a four-target sleep timer. Each
// item is either a 1 ms tick or a software write; the block takes one item per clock
// cycle unless an untaken result stalls it (result_ready low) and returns one result
// per item through the item register and then the result register. All divider and
// countdown updates for an item are resolved combinationally between those registers,
// so throughput is set only by result_ready. Configuration registers sit on the APB
// port at byte addresses 0x00 to 0x14 and should be written while no item is in flight.
module multi_rate_time_base_with_sleep_timer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            operation,
	input  logic [mrtb_pkg::TARGET_W-1:0]   target,
	input  logic [mrtb_pkg::VALUE_W-1:0]    value,
	input  logic                            low_voltage,
	input  logic                            clock_set_mode,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [mrtb_pkg::EVENTS_W-1:0]   tick_events,
	output logic [mrtb_pkg::MINUTE_W-1:0]   clock_minute,
	output logic [mrtb_pkg::HOUR_W-1:0]     clock_hour,
	output logic                            colon_on,
	output logic                            digits_on,
	output logic                            watchdog_kick,
	output logic                            shutdown_request,
	output logic                            sleep_expired,
	output logic                            overlay_expired,
	output logic                            fast_delay_busy,
	output logic                            slow_delay_busy,
	output logic [mrtb_pkg::COUNT_W-1:0]    charger_count_out,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mrtb_pkg::PADDR_W-1:0]    paddr,
	input  logic [mrtb_pkg::PDATA_W-1:0]    pwdata,
	output logic [mrtb_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import mrtb_pkg::*;

	logic [SLEEP_W-1:0]  sleep_one_q, sleep_two_q, sleep_three_q, sleep_four_q;
	logic [LV_W-1:0]     low_volt_cfg_q;
	logic [COUNT_W-1:0]  wdog_cfg_q;
	logic [2:0]          reg_idx;
	logic                cfg_wr;

	logic                valid_s1;
	logic                op_s1;
	logic [TARGET_W-1:0] target_s1;
	logic [VALUE_W-1:0]  value_s1;
	logic                low_s1;
	logic                setting_s1;
	logic                advance;

	logic [3:0]          ms_q, ms_d, ms_inc;
	logic [COUNT_W-1:0]  five_q, five_d, five_inc;
	logic [MINUTE_W-1:0] sec_q, sec_d, sec_inc;
	logic [COUNT_W-1:0]  wdog_q, wdog_d, wdog_inc;
	logic [LV_W-1:0]     lv_q, lv_d, lv_inc;
	logic [MINUTE_W-1:0] minute_q, minute_d;
	logic [HOUR_W-1:0]   hour_q, hour_d;
	logic                colon_q, colon_d, digit_q, digit_d;
	logic [COUNT_W-1:0]  charger_q, charger_d, alarm_q, alarm_d, overlay_q, overlay_d;
	logic [8:0]          fast_q, fast_d;
	logic [COUNT_W-1:0]  slow_q, slow_d;
	logic [2:0]          sleep_mode_q, sleep_mode_d;
	logic [SLEEP_W-1:0]  sleep_min_q, sleep_min_d, sleep_min_inc, sleep_tgt;
	logic                sleep_tgt_ok;
	logic                shutdown_q, shutdown_d, sleep_flag_q, sleep_flag_d;
	logic [EVENTS_W-1:0] ev;
	logic                kick, ovl;

	logic                valid_s2;
	logic [EVENTS_W-1:0] ev_s2;
	logic [MINUTE_W-1:0] minute_s2;
	logic [HOUR_W-1:0]   hour_s2;
	logic                colon_s2, digit_s2, kick_s2, shutdown_s2, sleep_flag_s2;
	logic                ovl_s2, fast_busy_s2, slow_busy_s2;
	logic [COUNT_W-1:0]  charger_s2;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_one_q    <= SLEEP_ONE_RST;
			sleep_two_q    <= SLEEP_TWO_RST;
			sleep_three_q  <= SLEEP_THREE_RST;
			sleep_four_q   <= SLEEP_FOUR_RST;
			low_volt_cfg_q <= LOW_VOLT_RST;
			wdog_cfg_q     <= WATCHDOG_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SLEEP_ONE:   sleep_one_q    <= pwdata[SLEEP_W-1:0];
				REG_SLEEP_TWO:   sleep_two_q    <= pwdata[SLEEP_W-1:0];
				REG_SLEEP_THREE: sleep_three_q  <= pwdata[SLEEP_W-1:0];
				REG_SLEEP_FOUR:  sleep_four_q   <= pwdata[SLEEP_W-1:0];
				REG_LOW_VOLT:    low_volt_cfg_q <= pwdata[LV_W-1:0];
				REG_WATCHDOG:    wdog_cfg_q     <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SLEEP_ONE:   prdata = {{(PDATA_W-SLEEP_W){1'b0}}, sleep_one_q};
			REG_SLEEP_TWO:   prdata = {{(PDATA_W-SLEEP_W){1'b0}}, sleep_two_q};
			REG_SLEEP_THREE: prdata = {{(PDATA_W-SLEEP_W){1'b0}}, sleep_three_q};
			REG_SLEEP_FOUR:  prdata = {{(PDATA_W-SLEEP_W){1'b0}}, sleep_four_q};
			REG_LOW_VOLT:    prdata = {{(PDATA_W-LV_W){1'b0}}, low_volt_cfg_q};
			REG_WATCHDOG:    prdata = {{(PDATA_W-COUNT_W){1'b0}}, wdog_cfg_q};
			default:         prdata = '0;
		endcase
	end

	// item register
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1      <= operation;
			target_s1  <= target;
			value_s1   <= value;
			low_s1     <= low_voltage;
			setting_s1 <= clock_set_mode;
		end
	end

	assign ms_inc        = ms_q + 4'd1;
	assign five_inc      = five_q + 8'd1;
	assign sec_inc       = sec_q + 6'd1;
	assign wdog_inc      = wdog_q + 8'd1;
	assign lv_inc        = lv_q + 3'd1;
	assign sleep_min_inc = sleep_min_q + 10'd1;

	always_comb begin
		sleep_tgt_ok = 1'b1;
		unique case (sleep_mode_q)
			SLEEP_ONE:   sleep_tgt = sleep_one_q;
			SLEEP_TWO:   sleep_tgt = sleep_two_q;
			SLEEP_THREE: sleep_tgt = sleep_three_q;
			SLEEP_FOUR:  sleep_tgt = sleep_four_q;
			default: begin
				sleep_tgt    = '0;
				sleep_tgt_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		ms_d         = ms_q;
		five_d       = five_q;
		sec_d        = sec_q;
		wdog_d       = wdog_q;
		lv_d         = lv_q;
		minute_d     = minute_q;
		hour_d       = hour_q;
		colon_d      = colon_q;
		digit_d      = digit_q;
		charger_d    = charger_q;
		alarm_d      = alarm_q;
		overlay_d    = overlay_q;
		fast_d       = fast_q;
		slow_d       = slow_q;
		sleep_mode_d = sleep_mode_q;
		sleep_min_d  = sleep_min_q;
		shutdown_d   = shutdown_q;
		sleep_flag_d = sleep_flag_q;
		ev           = '0;
		kick         = 1'b0;
		ovl          = 1'b0;
		if (op_s1 == OP_WRITE) begin
			unique case (target_s1)
				TGT_CHARGER: charger_d = value_s1;
				TGT_ALARM:   alarm_d   = value_s1;
				TGT_OVERLAY: overlay_d = value_s1;
				TGT_MINUTE:
					minute_d = (value_s1 > {2'b00, MINUTE_MAX}) ? MINUTE_MAX
						: value_s1[MINUTE_W-1:0];
				TGT_HOUR:
					hour_d = (value_s1 > {3'b000, HOUR_MAX}) ? HOUR_MAX
						: value_s1[HOUR_W-1:0];
				TGT_SLEEP_MODE: begin
					sleep_mode_d = value_s1[2:0];
					sleep_min_d  = '0;
				end
				TGT_CLEAR: begin
					if (value_s1[0]) shutdown_d   = 1'b0;
					if (value_s1[1]) sleep_flag_d = 1'b0;
				end
				TGT_FAST_DELAY: fast_d = {1'b0, value_s1} + 9'd1;
				TGT_SLOW_DELAY: slow_d = value_s1;
				default: ;
			endcase
		end else begin
			ms_d   = ms_inc;
			fast_d = (fast_q != '0) ? fast_q - 9'd1 : fast_q;
			ev[0]  = is_mult3(ms_inc);
			ev[1]  = !ms_inc[0];
			if (is_mult5(ms_inc)) begin
				ev[2]  = 1'b1;
				slow_d = (slow_q != '0) ? slow_q - 8'd1 : slow_q;
				five_d = five_inc;
				if (!five_inc[0]) begin
					ev[3] = 1'b1;
					ms_d  = '0;
					if (wdog_inc > wdog_cfg_q) begin
						wdog_d = '0;
						kick   = 1'b1;
					end else begin
						wdog_d = wdog_inc;
					end
				end
				if ((five_inc == '0) || (five_inc == SLOTS_HALF) ||
						(five_inc == SLOTS_SECOND)) begin
					ev[4]   = 1'b1;
					colon_d = !colon_q;
					if (setting_s1) digit_d = !digit_q;
				end
				if (five_inc == SLOTS_SECOND) begin
					ev[5]  = 1'b1;
					five_d = '0;
					if (low_s1) begin
						if (lv_inc == low_volt_cfg_q) begin
							shutdown_d = 1'b1;
							lv_d       = '0;
						end else begin
							lv_d = lv_inc;
						end
					end else begin
						lv_d = '0;
					end
					charger_d = hold_dec(charger_q);
					alarm_d   = hold_dec(alarm_q);
					overlay_d = (overlay_q != '0) ? overlay_q - 8'd1 : overlay_q;
					ovl       = (overlay_d == '0);
					sec_d     = sec_inc;
					if ((sec_inc == '0) || (sec_inc == SEC_PER_MIN)) begin
						ev[6] = 1'b1;
						sec_d = '0;
						if (minute_q < MINUTE_MAX) begin
							minute_d = minute_q + 6'd1;
						end else begin
							minute_d = '0;
							hour_d   = (hour_q < HOUR_MAX) ? hour_q + 5'd1 : '0;
						end
						if (sleep_mode_q != SLEEP_OFF) begin
							sleep_min_d = sleep_min_inc;
							if (sleep_tgt_ok && (sleep_min_inc == sleep_tgt)) begin
								sleep_flag_d = 1'b1;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q         <= '0;
			five_q       <= '0;
			sec_q        <= '0;
			wdog_q       <= '0;
			lv_q         <= '0;
			minute_q     <= '0;
			hour_q       <= '0;
			colon_q      <= 1'b0;
			digit_q      <= 1'b0;
			charger_q    <= '0;
			alarm_q      <= '0;
			overlay_q    <= '0;
			fast_q       <= '0;
			slow_q       <= '0;
			sleep_mode_q <= SLEEP_OFF;
			sleep_min_q  <= '0;
			shutdown_q   <= 1'b0;
			sleep_flag_q <= 1'b0;
		end else if (advance) begin
			ms_q         <= ms_d;
			five_q       <= five_d;
			sec_q        <= sec_d;
			wdog_q       <= wdog_d;
			lv_q         <= lv_d;
			minute_q     <= minute_d;
			hour_q       <= hour_d;
			colon_q      <= colon_d;
			digit_q      <= digit_d;
			charger_q    <= charger_d;
			alarm_q      <= alarm_d;
			overlay_q    <= overlay_d;
			fast_q       <= fast_d;
			slow_q       <= slow_d;
			sleep_mode_q <= sleep_mode_d;
			sleep_min_q  <= sleep_min_d;
			shutdown_q   <= shutdown_d;
			sleep_flag_q <= sleep_flag_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_s2         <= ev;
			minute_s2     <= minute_d;
			hour_s2       <= hour_d;
			colon_s2      <= colon_d;
			digit_s2      <= digit_d;
			kick_s2       <= kick;
			shutdown_s2   <= shutdown_d;
			sleep_flag_s2 <= sleep_flag_d;
			ovl_s2        <= ovl;
			fast_busy_s2  <= (fast_d != '0);
			slow_busy_s2  <= (slow_d != '0);
			charger_s2    <= charger_d;
		end
	end

	assign result_valid      = valid_s2;
	assign tick_events       = ev_s2;
	assign clock_minute      = minute_s2;
	assign clock_hour        = hour_s2;
	assign colon_on          = colon_s2;
	assign digits_on         = digit_s2;
	assign watchdog_kick     = kick_s2;
	assign shutdown_request  = shutdown_s2;
	assign sleep_expired     = sleep_flag_s2;
	assign overlay_expired   = ovl_s2;
	assign fast_delay_busy   = fast_busy_s2;
	assign slow_delay_busy   = slow_busy_s2;
	assign charger_count_out = charger_s2;

	a_kick_on_ten_ms: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && watchdog_kick |-> tick_events[3])
		else $error("watchdog kick without 10 ms event");

	a_minute_on_second: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && tick_events[6] |-> tick_events[5] && tick_events[4])
		else $error("minute event without second event");

	a_overlay_on_second: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && overlay_expired |-> tick_events[5])
		else $error("overlay expiry off a second boundary");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		minute_q <= MINUTE_MAX && hour_q <= HOUR_MAX)
		else $error("clock out of range");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("item lost between stages");

endmodule
